// ===== design/pctan_pkg.sv =====
package pctan_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 30;

  // CORDIC datapath width: x, y and residual angle, Q.30 with headroom
  localparam int CW = 33;

  // Angle constants, Q.30
  localparam logic signed [35:0] Q30_TWO_PI   = 36'sd6746518852;
  localparam logic signed [35:0] Q30_PI       = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI  = 36'sd1686629713;
  localparam logic signed [35:0] Q30_THREE_PI = 36'sd10119778278;
  localparam logic signed [35:0] Q30_FOUR_PI  = 36'sd13493037704;
  localparam logic signed [31:0] Q30_GAIN     = 32'sd652032874;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z   = 3'd6;

  // Curve kinds; the unused code falls back to a circle
  localparam logic [1:0] KIND_CIRCLE  = 2'd0;
  localparam logic [1:0] KIND_ELLIPSE = 2'd1;
  localparam logic [1:0] KIND_HELIX   = 2'd2;

  typedef struct packed {
    logic [1:0]         curve_kind;
    logic [30:0]        radius_a;
    logic [30:0]        radius_b;
    logic [30:0]        pitch;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } cfg_t;

  // Travels with each item down the pipeline
  typedef struct packed {
    logic               valid;
    logic               cneg;
    logic signed [31:0] angle;
  } tag_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  localparam int SAT_W = 64;
  localparam logic signed [SAT_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
    sat_t res;
    res.clip = 1'b0;
    res.val  = v[31:0];
    if (v > SAT_MAX) begin
      res.clip = 1'b1;
      res.val  = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      res.clip = 1'b1;
      res.val  = SAT_MIN[31:0];
    end
    return res;
  endfunction

  // atan(2^-i), Q.30, rounded to nearest
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:  return 32'd843314857;
      5'd1:  return 32'd497837829;
      5'd2:  return 32'd263043837;
      5'd3:  return 32'd133525159;
      5'd4:  return 32'd67021687;
      5'd5:  return 32'd33543516;
      5'd6:  return 32'd16775851;
      5'd7:  return 32'd8388437;
      5'd8:  return 32'd4194283;
      5'd9:  return 32'd2097149;
      5'd10: return 32'd1048576;
      5'd11: return 32'd524288;
      5'd12: return 32'd262144;
      5'd13: return 32'd131072;
      5'd14: return 32'd65536;
      5'd15: return 32'd32768;
      5'd16: return 32'd16384;
      5'd17: return 32'd8192;
      5'd18: return 32'd4096;
      5'd19: return 32'd2048;
      5'd20: return 32'd1024;
      5'd21: return 32'd512;
      5'd22: return 32'd256;
      5'd23: return 32'd128;
      5'd24: return 32'd64;
      5'd25: return 32'd32;
      5'd26: return 32'd16;
      5'd27: return 32'd8;
      5'd28: return 32'd4;
      5'd29: return 32'd2;
      default: return 32'd0;
    endcase
  endfunction

endpackage

// ===== design/pctan_reduce.sv =====
module pctan_reduce import pctan_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] in_angle,
  output tag_t               tag_o,
  output logic signed [31:0] z_o
);

  localparam int SH    = 30 - FRAC_BITS;
  localparam int T30_W = 32 + SH;
  localparam int Q_W   = SH + 2;
  localparam int M_W   = Q_W + 36;
  localparam int D_W   = M_W + 1;
  localparam int R0_W  = 36;
  localparam int R_W   = 34;

  // floor(2^(32+SH) / 2pi): quotient estimate is off by at most one
  localparam longint RECIP_L = (64'sd1 <<< (32 + SH)) / longint'(Q30_TWO_PI);
  localparam logic signed [32:0] RECIP = 33'(RECIP_L);

  logic                     v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [31:0]       ang1_r, ang2_r, ang3_r, ang4_r, ang5_r;
  logic signed [64:0]       prod1;
  logic signed [Q_W-1:0]    q1_r;
  logic signed [M_W-1:0]    m2;
  logic signed [M_W-1:0]    m2_r;
  logic signed [T30_W-1:0]  t30;
  logic signed [D_W-1:0]    d3;
  logic signed [R0_W-1:0]   r0_r;
  logic signed [R0_W-1:0]   rc;
  logic signed [R_W-1:0]    r4_r;
  logic signed [R0_W-1:0]   fz;
  logic                     fneg;
  logic signed [31:0]       z5_r;
  logic                     cneg5_r;

  assign prod1 = in_angle * RECIP;
  assign m2    = q1_r * Q30_TWO_PI;
  assign t30   = {ang2_r, {SH{1'b0}}};
  assign d3    = D_W'(t30) - D_W'(m2_r);

  // Bring the remainder into [-pi, pi)
  always_comb begin
    if (r0_r < -Q30_PI) begin
      rc = r0_r + Q30_TWO_PI;
    end else if (r0_r >= Q30_THREE_PI) begin
      rc = r0_r - Q30_FOUR_PI;
    end else if (r0_r >= Q30_PI) begin
      rc = r0_r - Q30_TWO_PI;
    end else begin
      rc = r0_r;
    end
  end

  // Fold into [-pi/2, pi/2]; cosine flips sign
  always_comb begin
    fz   = R0_W'(r4_r);
    fneg = 1'b0;
    if (r4_r > Q30_HALF_PI) begin
      fz   = Q30_PI - R0_W'(r4_r);
      fneg = 1'b1;
    end else if (r4_r < -Q30_HALF_PI) begin
      fz   = -Q30_PI - R0_W'(r4_r);
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r    <= Q_W'(prod1 >>> 32);
      ang1_r  <= in_angle;
      m2_r    <= m2;
      ang2_r  <= ang1_r;
      r0_r    <= R0_W'(d3);
      ang3_r  <= ang2_r;
      r4_r    <= R_W'(rc);
      ang4_r  <= ang3_r;
      z5_r    <= 32'(fz);
      cneg5_r <= fneg;
      ang5_r  <= ang4_r;
    end
  end

  assign tag_o = '{valid: v5_r, cneg: cneg5_r, angle: ang5_r};
  assign z_o   = z5_r;

endmodule

// ===== design/pctan_cordic.sv =====
module pctan_cordic import pctan_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  tag_t                 tag_i,
  input  logic signed [31:0]   z_i,
  output tag_t                 tag_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o
);

  logic signed [CW-1:0] x_r [CORDIC_STAGES];
  logic signed [CW-1:0] y_r [CORDIC_STAGES];
  logic signed [CW-1:0] z_r [CORDIC_STAGES-1];
  tag_t                 tag_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(5'(i)));

    logic signed [CW-1:0] xp, yp, zp;
    logic signed [CW-1:0] xn, yn, zn;
    tag_t                 tp;

    if (i == 0) begin : g_first
      assign xp = CW'(Q30_GAIN);
      assign yp = '0;
      assign zp = CW'(z_i);
      assign tp = tag_i;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign tp = tag_r[i-1];
    end

    always_comb begin
      if (!zp[CW-1]) begin
        xn = xp - (yp >>> i);
        yn = yp + (xp >>> i);
        zn = zp - ATAN;
      end else begin
        xn = xp + (yp >>> i);
        yn = yp - (xp >>> i);
        zn = zp + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i].valid <= 1'b0;
      end else if (en) begin
        tag_r[i] <= tp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= xn;
        y_r[i] <= yn;
      end
    end

    // the last residual angle steers nothing
    if (i < CORDIC_STAGES - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i] <= zn;
        end
      end
    end
  end

  assign tag_o = tag_r[CORDIC_STAGES-1];
  assign x_o   = x_r[CORDIC_STAGES-1];
  assign y_o   = y_r[CORDIC_STAGES-1];

endmodule

// ===== design/pctan_scale.sv =====
module pctan_scale import pctan_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  tag_t                 tag_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  output logic                 res_valid,
  output result_t              res
);

  localparam int RS_W = 34;
  localparam int PZ_W = 64 - FRAC_BITS;
  localparam logic signed [63:0] ROUND30 = 64'sd1 <<< 29;
  localparam logic signed [63:0] ROUNDF  = 64'sd1 <<< (FRAC_BITS - 1);

  logic                   v1_r, v2_r, v3_r, v4_r;
  logic signed [CW-1:0]   c1_r, s1_r;
  logic signed [31:0]     ang1_r;
  logic signed [31:0]     a_s, b_s, p_s;
  logic signed [63:0]     ac2_r, bs2_r, as2_r, bc2_r, pt2_r;
  logic signed [31:0]     p2_r, p3_r;
  logic signed [RS_W-1:0] ac3_r, bs3_r, as3_r, bc3_r;
  logic signed [PZ_W-1:0] pz3_r;
  sat_t                   px_s, py_s, pz_s, tx_s, ty_s, tz_s;
  result_t                res_nxt;
  result_t                res_r;

  assign a_s = signed'({1'b0, cfg.radius_a});
  assign b_s = (cfg.curve_kind == KIND_ELLIPSE) ? signed'({1'b0, cfg.radius_b}) : a_s;
  assign p_s = (cfg.curve_kind == KIND_HELIX) ? signed'({1'b0, cfg.pitch}) : 32'sd0;

  always_comb begin
    px_s = sat32(SAT_W'(cfg.center_x) + SAT_W'(ac3_r));
    py_s = sat32(SAT_W'(cfg.center_y) + SAT_W'(bs3_r));
    pz_s = sat32(SAT_W'(cfg.center_z) + SAT_W'(pz3_r));
    tx_s = sat32(-SAT_W'(as3_r));
    ty_s = sat32(SAT_W'(bc3_r));
    tz_s = sat32(SAT_W'(p3_r));
    res_nxt.pos_x     = px_s.val;
    res_nxt.pos_y     = py_s.val;
    res_nxt.pos_z     = pz_s.val;
    res_nxt.tan_x     = tx_s.val;
    res_nxt.tan_y     = ty_s.val;
    res_nxt.tan_z     = tz_s.val;
    res_nxt.saturated = px_s.clip | py_s.clip | pz_s.clip
                      | tx_s.clip | ty_s.clip | tz_s.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= tag_i.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= tag_i.cneg ? -x_i : x_i;
      s1_r   <= y_i;
      ang1_r <= tag_i.angle;

      ac2_r  <= a_s * c1_r;
      bs2_r  <= b_s * s1_r;
      as2_r  <= a_s * s1_r;
      bc2_r  <= b_s * c1_r;
      pt2_r  <= p_s * ang1_r;
      p2_r   <= p_s;

      // round to nearest, halves upward
      ac3_r  <= RS_W'((ac2_r + ROUND30) >>> 30);
      bs3_r  <= RS_W'((bs2_r + ROUND30) >>> 30);
      as3_r  <= RS_W'((as2_r + ROUND30) >>> 30);
      bc3_r  <= RS_W'((bc2_r + ROUND30) >>> 30);
      pz3_r  <= PZ_W'((pt2_r + ROUNDF) >>> FRAC_BITS);
      p3_r   <= p2_r;

      res_r  <= res_nxt;
    end
  end

  assign res_valid = v4_r;
  assign res       = res_r;

endmodule

// ===== design/pctan_outbuf.sv =====
module pctan_outbuf import pctan_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    p_valid,
  input  result_t p_data,
  output logic    en,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_v_r, skid_v_r;
  result_t out_d_r, skid_d_r;
  logic    out_free;

  assign out_free = !out_v_r || out_ready;
  // advance the pipeline while the skid slot is empty
  assign en       = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_free) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (p_valid) begin
      if (out_free) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_free) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_free) begin
        out_d_r <= skid_d_r;
      end
    end else if (p_valid) begin
      if (out_free) begin
        out_d_r <= p_data;
      end else begin
        skid_d_r <= p_data;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== design/parametric_curve_point_tangent.sv =====
// Point and tangent of a circle, ellipse or helix at curve parameter t (Q16.16
// radians by default). Takes one angle per clock while in_ready is high and
// returns one result per angle, in order. The edge that takes an angle loads
// the first of CORDIC_STAGES + 10 register stages (5 of range reduction, one
// per CORDIC stage, 4 of scaling and saturation, and the output register). The
// pipeline stalls as a whole only when both the output register and its skid
// slot are full; in_ready is low exactly then. Configuration writes (cfg_index
// 0..6: kind, radius_a, radius_b, pitch, center_x, center_y, center_z) take
// effect at once and should be made only while the pipeline is empty;
// cfg_index 7 is ignored.
module parametric_curve_point_tangent import pctan_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_angle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_pos_z,
  output logic signed [31:0]   out_tan_x,
  output logic signed [31:0]   out_tan_y,
  output logic signed [31:0]   out_tan_z,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t                 cfg_r;
  logic                 en;
  tag_t                 red_tag, cor_tag;
  logic signed [31:0]   red_z;
  logic signed [CW-1:0] cor_x, cor_y;
  logic                 res_valid;
  result_t              res, out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve_kind <= KIND_CIRCLE;
      cfg_r.radius_a   <= 31'd65536;
      cfg_r.radius_b   <= 31'd65536;
      cfg_r.pitch      <= '0;
      cfg_r.center_x   <= '0;
      cfg_r.center_y   <= '0;
      cfg_r.center_z   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CURVE_KIND: cfg_r.curve_kind <= cfg_data[1:0];
        REG_RADIUS_A:   cfg_r.radius_a   <= cfg_data[30:0];
        REG_RADIUS_B:   cfg_r.radius_b   <= cfg_data[30:0];
        REG_PITCH:      cfg_r.pitch      <= cfg_data[30:0];
        REG_CENTER_X:   cfg_r.center_x   <= cfg_data;
        REG_CENTER_Y:   cfg_r.center_y   <= cfg_data;
        REG_CENTER_Z:   cfg_r.center_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = en;

  pctan_reduce #(
    .FRAC_BITS(FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_angle (in_angle),
    .tag_o    (red_tag),
    .z_o      (red_z)
  );

  pctan_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (red_tag),
    .z_i   (red_z),
    .tag_o (cor_tag),
    .x_o   (cor_x),
    .y_o   (cor_y)
  );

  pctan_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .tag_i     (cor_tag),
    .x_i       (cor_x),
    .y_i       (cor_y),
    .res_valid (res_valid),
    .res       (res)
  );

  pctan_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .p_valid   (res_valid),
    .p_data    (res),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_pos_x     = out_data.pos_x;
  assign out_pos_y     = out_data.pos_y;
  assign out_pos_z     = out_data.pos_z;
  assign out_tan_x     = out_data.tan_x;
  assign out_tan_y     = out_data.tan_y;
  assign out_tan_z     = out_data.tan_z;
  assign out_saturated = out_data.saturated;

endmodule

// ===== design/pctan_checker.sv =====
module pctan_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_tan_x,
  input logic [31:0] out_tan_z
);

  // reset empties the output side and reopens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_tan_x))
    else $error("stalled result changed");

  // input closes only when both output register and skid slot hold a result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_stall_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_ready |=> in_ready)
    else $error("input still stalled after output drained");

  // pitch is never negative
  a_tan_z_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_tan_z[31])
    else $error("negative tangent z");

endmodule

bind parametric_curve_point_tangent pctan_checker u_pctan_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import pctan_pkg::*;

  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint CLIP_HI     = 64'sd2147483647;
  localparam longint CLIP_LO     = -64'sd2147483648;

  localparam logic [31:0] HALF_PI_Q16 = 32'd102944;
  localparam logic [31:0] PI_Q16      = 32'd205887;
  localparam logic [31:0] TWO_PI_Q16  = 32'd411775;

  // index past the last register; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // curve kind code with no curve of its own
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int LATENCY       = CORDIC_STAGES_DEF + 9;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 200;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 120;

  typedef enum {STEP_ANGLE, STEP_WRITE, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [31:0]          value;
    logic [CFG_IDX_W-1:0] idx;
    int                   gap;
    bit                   long_hold;
  } step_t;

  typedef struct {
    result_t point;
    bit      long_hold;
  } curve_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   in_angle = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [31:0]   out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0]   out_tan_x, out_tan_y, out_tan_z;
  logic                 out_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  step_t         stimulus_plan[$];
  curve_sample_t pending_points[$];
  cfg_t          curve_regs;
  int            err_count = 0;

  longint atan_step [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64,
    32, 16, 8, 4, 2
  };

  parametric_curve_point_tangent DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_angle      (in_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .out_tan_x     (out_tan_x),
    .out_tan_y     (out_tan_y),
    .out_tan_z     (out_tan_z),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [32:0] clip32(input longint v);
    if (v > CLIP_HI) return {1'b1, 32'h7FFF_FFFF};
    if (v < CLIP_LO) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic result_t curve_point_tangent(input logic signed [31:0] ang);
    longint t, t30, r, x, y, nx, sn, cs, a, b, p;
    bit cneg, ellipse, helix, clipped;
    logic [32:0] q;
    result_t res;
    t = longint'(ang);
    t30 = t * (longint'(1) << (30 - FRAC_BITS_DEF));
    // reduce by 2*pi (truncating division), then fold into [-pi/2, pi/2]
    r = t30 - (t30 / TWO_PI_Q30) * TWO_PI_Q30;
    if (r >= PI_Q30) r = r - TWO_PI_Q30;
    if (r < -PI_Q30) r = r + TWO_PI_Q30;
    cneg = 1'b0;
    if (r > HALF_PI_Q30) begin
      r = PI_Q30 - r;
      cneg = 1'b1;
    end else if (r < -HALF_PI_Q30) begin
      r = -PI_Q30 - r;
      cneg = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF && i < 30; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r = r - atan_step[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r = r + atan_step[i];
      end
      x = nx;
    end
    sn = y;
    cs = cneg ? -x : x;

    ellipse = (curve_regs.curve_kind == KIND_ELLIPSE);
    helix = (curve_regs.curve_kind == KIND_HELIX);
    a = longint'(curve_regs.radius_a);
    b = ellipse ? longint'(curve_regs.radius_b) : a;
    p = helix ? longint'(curve_regs.pitch) : 0;

    clipped = 1'b0;
    q = clip32(longint'($signed(curve_regs.center_x)) + round_shift(a * cs, 30));
    res.pos_x = q[31:0];
    clipped |= q[32];
    q = clip32(longint'($signed(curve_regs.center_y)) + round_shift(b * sn, 30));
    res.pos_y = q[31:0];
    clipped |= q[32];
    q = clip32(longint'($signed(curve_regs.center_z)) +
               (helix ? round_shift(p * t, FRAC_BITS_DEF) : 0));
    res.pos_z = q[31:0];
    clipped |= q[32];
    q = clip32(-round_shift(a * sn, 30));
    res.tan_x = q[31:0];
    clipped |= q[32];
    q = clip32(round_shift(b * cs, 30));
    res.tan_y = q[31:0];
    clipped |= q[32];
    q = clip32(p);
    res.tan_z = q[31:0];
    clipped |= q[32];
    res.saturated = clipped;
    return res;
  endfunction

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    case (idx)
      REG_CURVE_KIND: curve_regs.curve_kind = v[1:0];
      REG_RADIUS_A:   curve_regs.radius_a = v[30:0];
      REG_RADIUS_B:   curve_regs.radius_b = v[30:0];
      REG_PITCH:      curve_regs.pitch = v[30:0];
      REG_CENTER_X:   curve_regs.center_x = v;
      REG_CENTER_Y:   curve_regs.center_y = v;
      REG_CENTER_Z:   curve_regs.center_z = v;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: angles, register writes and drain points, in plan order
  // ---------------------------------------------------------------------------
  step_t cur_step;
  bit    have_step = 1'b0;
  bit    offer_hold = 1'b0;
  int    gap_cnt = 0;
  int    settle_cnt = 0;

  always @(posedge clk) begin : driver
    logic nv_in, nv_cfg;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      have_step = 1'b0;
      gap_cnt = 0;
      settle_cnt = 0;
      curve_regs.curve_kind = KIND_CIRCLE;
      curve_regs.radius_a = 31'd65536;
      curve_regs.radius_b = 31'd65536;
      curve_regs.pitch = '0;
      curve_regs.center_x = '0;
      curve_regs.center_y = '0;
      curve_regs.center_z = '0;
    end else begin
      nv_in = in_valid;
      nv_cfg = cfg_valid;
      if (in_valid && in_ready) begin
        pending_points.push_back('{point: curve_point_tangent(in_angle),
                                   long_hold: offer_hold});
        nv_in = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        nv_cfg = 1'b0;
      end
      if (!nv_in && !nv_cfg) begin
        if (!have_step && stimulus_plan.size() > 0) begin
          cur_step = stimulus_plan.pop_front();
          have_step = 1'b1;
          gap_cnt = cur_step.gap;
        end
        if (have_step) begin
          case (cur_step.kind)
            STEP_ANGLE: begin
              if (gap_cnt == 0) begin
                in_angle <= cur_step.value;
                offer_hold = cur_step.long_hold;
                nv_in = 1'b1;
                have_step = 1'b0;
              end else begin
                gap_cnt--;
              end
            end
            STEP_WRITE: begin
              cfg_index <= cur_step.idx;
              cfg_data <= cur_step.value;
              nv_cfg = 1'b1;
              have_step = 1'b0;
            end
            STEP_DRAIN: begin
              // hold until every result is back, then let the pipe settle
              if (pending_points.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
              end else begin
                settle_cnt = 0;
                have_step = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      in_valid <= nv_in;
      cfg_valid <= nv_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: back-pressure and result checking
  // ---------------------------------------------------------------------------
  int hold_cnt = 0;
  bit rx_steady = 1'b0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, name, $signed(want), want, $signed(got), got);
    end
  endtask

  always @(posedge clk) begin : monitor
    logic nxt_ready;
    curve_sample_t exp_pt;
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      nxt_ready = out_ready;
      if (out_valid && out_ready) begin
        w = 0;
        if (pending_points.size() == 0) begin
          err_count++;
          $display("%0t: unexpected transaction, expected none, actual pos_x %0d",
                   $time, out_pos_x);
        end else begin
          exp_pt = pending_points.pop_front();
          check_field("pos_x", exp_pt.point.pos_x, out_pos_x);
          check_field("pos_y", exp_pt.point.pos_y, out_pos_y);
          check_field("pos_z", exp_pt.point.pos_z, out_pos_z);
          check_field("tan_x", exp_pt.point.tan_x, out_tan_x);
          check_field("tan_y", exp_pt.point.tan_y, out_tan_y);
          check_field("tan_z", exp_pt.point.tan_z, out_tan_z);
          check_field("saturated", {31'd0, exp_pt.point.saturated},
                      {31'd0, out_saturated});
          if (exp_pt.long_hold) w = LONG_HOLD;
        end
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        if (w == 0 && !rx_steady) w = $urandom_range(0, 10);
        hold_cnt = w;
        nxt_ready = (w == 0);
      end else if (!out_ready) begin
        if (hold_cnt <= 1) begin
          hold_cnt = 0;
          nxt_ready = 1'b1;
        end else begin
          hold_cnt--;
        end
      end
      out_ready <= nxt_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan
  // ---------------------------------------------------------------------------
  task automatic add_angle(input logic [31:0] v, input int gap, input bit hold);
    step_t s;
    s.kind = STEP_ANGLE;
    s.value = v;
    s.idx = '0;
    s.gap = gap;
    s.long_hold = hold;
    stimulus_plan.push_back(s);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    step_t s;
    s.kind = STEP_WRITE;
    s.value = v;
    s.idx = idx;
    s.gap = 0;
    s.long_hold = 1'b0;
    stimulus_plan.push_back(s);
  endtask

  task automatic add_drain();
    step_t s;
    s.kind = STEP_DRAIN;
    s.value = '0;
    s.idx = '0;
    s.gap = 0;
    s.long_hold = 1'b0;
    stimulus_plan.push_back(s);
  endtask

  function automatic logic [31:0] random_magnitude();
    logic [30:0] m;
    case ($urandom_range(0, 5))
      0:       m = '0;
      1:       m = 31'h7FFF_FFFF;
      2:       m = 31'd65536;
      3:       m = 31'($urandom_range(0, 32'h3_FFFF));
      4:       m = 31'($urandom_range(0, 32'hFF_FFFF));
      default: m = 31'($urandom);
    endcase
    // bit 31 is not part of the register
    return {$urandom_range(0, 1) == 1, m};
  endfunction

  function automatic logic [31:0] random_center();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_angle();
    int k;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1647100) - 32'd823550;
      2: begin
        // near a multiple of pi/2, where the fold changes quadrant
        k = int'($urandom_range(0, 16)) - 8;
        return k * HALF_PI_Q16 + $urandom_range(0, 8) - 32'd4;
      end
      default: return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
    endcase
  endfunction

  task automatic add_random_config();
    logic [31:0] kind_word;
    kind_word = $urandom;
    kind_word[1:0] = 2'($urandom_range(0, 3));
    add_write(REG_CURVE_KIND, kind_word);
    add_write(REG_RADIUS_A, random_magnitude());
    add_write(REG_RADIUS_B, random_magnitude());
    add_write(REG_PITCH, random_magnitude());
    add_write(REG_CENTER_X, random_center());
    add_write(REG_CENTER_Y, random_center());
    add_write(REG_CENTER_Z, random_center());
    if ($urandom_range(0, 3) == 0) add_write(REG_UNUSED, $urandom);
  endtask

  initial begin : plan_and_finish
    int gap_max;

    // circle of radius one at reset
    add_angle(32'd0, $urandom_range(0, 10), 1'b0);
    add_angle(32'd1, $urandom_range(0, 10), 1'b0);
    add_angle(32'hFFFF_FFFF, $urandom_range(0, 10), 1'b0);
    add_angle(HALF_PI_Q16, $urandom_range(0, 10), 1'b0);
    add_angle(-HALF_PI_Q16, $urandom_range(0, 10), 1'b0);
    add_angle(PI_Q16, $urandom_range(0, 10), 1'b0);
    add_angle(-PI_Q16, $urandom_range(0, 10), 1'b0);
    add_angle(TWO_PI_Q16, $urandom_range(0, 10), 1'b0);
    add_angle(32'h7FFF_FFFF, $urandom_range(0, 10), 1'b0);
    add_angle(32'h8000_0000, $urandom_range(0, 10), 1'b0);

    // a write past the register list changes nothing
    add_drain();
    add_write(REG_UNUSED, 32'hFFFF_FFFF);
    add_angle(32'd51472, $urandom_range(0, 10), 1'b0);

    // unused kind acts as a circle; largest radius against extreme centers
    add_drain();
    add_write(REG_CURVE_KIND, {30'd0, KIND_UNUSED});
    add_write(REG_RADIUS_A, 32'h7FFF_FFFF);
    add_write(REG_CENTER_X, 32'h7FFF_FFFF);
    add_write(REG_CENTER_Y, 32'h8000_0000);
    add_angle(32'd0, $urandom_range(0, 10), 1'b0);
    add_angle(-HALF_PI_Q16, $urandom_range(0, 10), 1'b0);

    add_drain();
    add_write(REG_CURVE_KIND, {30'd0, KIND_ELLIPSE});
    add_write(REG_RADIUS_B, 32'd0);
    add_angle(32'd25000, $urandom_range(0, 10), 1'b0);

    // helix with the steepest pitch drives pos_z to both rails
    add_drain();
    add_write(REG_CURVE_KIND, {30'd0, KIND_HELIX});
    add_write(REG_PITCH, 32'h7FFF_FFFF);
    add_write(REG_CENTER_Z, 32'h8000_0000);
    add_angle(32'h8000_0000, $urandom_range(0, 10), 1'b0);
    add_angle(32'h7FFF_FFFF, $urandom_range(0, 10), 1'b0);
    add_angle(32'hFFFF_FFFF, $urandom_range(0, 10), 1'b0);

    add_drain();
    add_write(REG_CURVE_KIND, {30'd0, KIND_ELLIPSE});
    add_write(REG_RADIUS_A, 32'd0);
    add_write(REG_RADIUS_B, 32'h7FFF_FFFF);
    add_write(REG_PITCH, 32'd0);
    add_angle(-HALF_PI_Q16, $urandom_range(0, 10), 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      add_drain();
      add_random_config();
      gap_max = (ph % 4 == 1) ? 0 : 10;
      for (int n = 0; n < PHASE_ITEMS; n++)
        add_angle(random_angle(), $urandom_range(0, gap_max),
                  (ph == 5 || ph == 13) && n == 0);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (stimulus_plan.size() != 0 || have_step || in_valid || cfg_valid)
      @(posedge clk);
    while (pending_points.size() != 0)
      @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== parametric_curve_point_tangent.f =====
design/pctan_pkg.sv
design/pctan_reduce.sv
design/pctan_cordic.sv
design/pctan_scale.sv
design/pctan_outbuf.sv
design/parametric_curve_point_tangent.sv
design/pctan_checker.sv
bench/testbench.sv
